### rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Types and constants for the PNG chunk deframer: item structs, parse
// phases, event codes, signature bytes and the known chunk tags.
// ----------------------------------------------------------------------------
package pcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_size;
    logic        is_critical;
    logic [31:0] stored_crc;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [7:0]  color_type;
    logic [7:0]  compression_method;
    logic [7:0]  filter_method;
    logic [7:0]  interlace_method;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TAG  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  localparam logic [1:0] EV_CHUNK   = 2'd0;
  localparam logic [1:0] EV_END     = 2'd1;
  localparam logic [1:0] EV_BAD_SIG = 2'd2;
  localparam logic [1:0] EV_UNKNOWN = 2'd3;

  localparam int SIG_LEN      = 8;
  localparam int NUM_TAGS     = 21;
  localparam int HDR_DATA_LEN = 13;

  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  // tags hold the first type byte in the low bits, so the strings read reversed
  localparam logic [31:0] TAG_IHDR = "RDHI";
  localparam logic [31:0] TAG_IEND = "DNEI";

  localparam logic [31:0] KNOWN_TAGS [NUM_TAGS] = '{
    "RDHI", "ETLP", "TADI", "DNEI", "DGKb", "MRHc", "GISd",
    "fIXe", "AMAg", "TSIh", "PCCi", "tXTi", "sYHp", "TIBs",
    "TLPs", "BGRs", "RETs", "tXEt", "EMIt", "SNRt", "tXTz"
  };

  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;

  function automatic logic tag_known(input logic [31:0] tag);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (KNOWN_TAGS[i] == tag) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### rtl/pcd_core.sv
// ----------------------------------------------------------------------------
// pcd_core
// Parse state of the deframer: signature check, length/tag/CRC assembly,
// data skip with IHDR capture. Produces at most one event per accepted byte.
// ----------------------------------------------------------------------------
module pcd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pcd_pkg::in_item_t   in_item,
  output logic                ev_valid,
  output pcd_pkg::out_item_t  ev_item
);

  pcd_pkg::phase_t phase_r, phase_nxt, e_phase;
  logic [31:0] idx_r, idx_nxt, e_idx;
  logic [31:0] len_r, len_nxt, e_len;
  logic [31:0] tag_r, tag_nxt, e_tag;
  logic [31:0] crc_r, crc_nxt, e_crc;
  logic        first_r, first_nxt, e_first;
  logic [31:0] width_r, width_nxt, e_width;
  logic [31:0] height_r, height_nxt, e_height;
  logic [39:0] hdr_r, hdr_nxt, e_hdr;

  logic [7:0]  b;
  logic [1:0]  i2;
  logic [2:0]  i3;
  logic [31:0] idx_inc;
  logic [31:0] tag_new;
  logic [31:0] crc_new;
  logic        sig_bad;
  logic        ev_bad, ev_unknown, ev_done;

  assign b       = in_item.data_byte;
  assign i2      = e_idx[1:0];
  assign i3      = e_idx[2:0];
  assign idx_inc = e_idx + 32'd1;

  // start of file restarts the parser at this byte
  always_comb begin
    if (in_item.start_of_file) begin
      e_phase  = pcd_pkg::PH_SIG;
      e_idx    = '0;
      e_len    = '0;
      e_tag    = '0;
      e_crc    = '0;
      e_first  = 1'b1;
      e_width  = '0;
      e_height = '0;
      e_hdr    = '0;
    end else begin
      e_phase  = phase_r;
      e_idx    = idx_r;
      e_len    = len_r;
      e_tag    = tag_r;
      e_crc    = crc_r;
      e_first  = first_r;
      e_width  = width_r;
      e_height = height_r;
      e_hdr    = hdr_r;
    end
  end

  assign sig_bad = (b != pcd_pkg::SIG_BYTES[i3]);
  assign tag_new = ((i2 == 2'd0) ? 32'd0 : e_tag) | ({24'd0, b} << {i2, 3'b000});
  assign crc_new = ((i2 == 2'd0) ? 32'd0 : e_crc) | ({24'd0, b} << {i2, 3'b000});

  // next state
  always_comb begin
    phase_nxt  = e_phase;
    idx_nxt    = e_idx;
    len_nxt    = e_len;
    tag_nxt    = e_tag;
    crc_nxt    = e_crc;
    first_nxt  = e_first;
    width_nxt  = e_width;
    height_nxt = e_height;
    hdr_nxt    = e_hdr;
    unique case (e_phase)
      pcd_pkg::PH_SIG: begin
        if (sig_bad) begin
          phase_nxt = pcd_pkg::PH_STOP;
        end else if (i3 == 3'd7) begin
          phase_nxt = pcd_pkg::PH_LEN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = {29'd0, i3 + 3'd1};
        end
      end
      pcd_pkg::PH_LEN: begin
        len_nxt = {((i2 == 2'd0) ? 24'd0 : e_len[23:0]), b};
        if (i2 == 2'd3) begin
          phase_nxt = pcd_pkg::PH_TAG;
          idx_nxt   = '0;
        end else begin
          idx_nxt = {30'd0, i2 + 2'd1};
        end
      end
      pcd_pkg::PH_TAG: begin
        tag_nxt = tag_new;
        if (i2 != 2'd3) begin
          idx_nxt = {30'd0, i2 + 2'd1};
        end else begin
          idx_nxt = '0;
          if (!pcd_pkg::tag_known(tag_new)) begin
            phase_nxt = pcd_pkg::PH_STOP;
          end else if (e_len == 32'd0) begin
            phase_nxt = pcd_pkg::PH_CRC;
          end else begin
            phase_nxt = pcd_pkg::PH_DATA;
          end
        end
      end
      pcd_pkg::PH_DATA: begin
        if (e_first && (e_tag == pcd_pkg::TAG_IHDR)
            && (e_idx < 32'(pcd_pkg::HDR_DATA_LEN))) begin
          if (e_idx[3:2] == 2'd0) begin
            width_nxt = e_width | ({24'd0, b} << {~i2, 3'b000});
          end else if (e_idx[3:2] == 2'd1) begin
            height_nxt = e_height | ({24'd0, b} << {~i2, 3'b000});
          end else begin
            hdr_nxt = e_hdr | ({32'd0, b} << {i3, 3'b000});
          end
        end
        if (idx_inc == e_len) begin
          phase_nxt = pcd_pkg::PH_CRC;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      pcd_pkg::PH_CRC: begin
        crc_nxt = crc_new;
        if (i2 != 2'd3) begin
          idx_nxt = {30'd0, i2 + 2'd1};
        end else begin
          idx_nxt   = '0;
          first_nxt = 1'b0;
          phase_nxt = (e_tag == pcd_pkg::TAG_IEND) ? pcd_pkg::PH_STOP : pcd_pkg::PH_LEN;
        end
      end
      default: begin
        phase_nxt = e_phase;
      end
    endcase
  end

  // event outputs
  always_comb begin
    ev_bad     = 1'b0;
    ev_unknown = 1'b0;
    ev_done    = 1'b0;
    unique case (e_phase)
      pcd_pkg::PH_SIG:  ev_bad     = sig_bad;
      pcd_pkg::PH_TAG:  ev_unknown = (i2 == 2'd3) && !pcd_pkg::tag_known(tag_new);
      pcd_pkg::PH_CRC:  ev_done    = (i2 == 2'd3);
      default:          ev_done    = 1'b0;
    endcase

    ev_valid = ev_bad || ev_unknown || ev_done;

    ev_item            = '0;
    ev_item.chunk_size = e_len;
    if (ev_bad) begin
      ev_item.event_kind = pcd_pkg::EV_BAD_SIG;
      ev_item.chunk_size = '0;
    end else if (ev_unknown) begin
      ev_item.event_kind = pcd_pkg::EV_UNKNOWN;
      ev_item.chunk_tag  = tag_new;
    end else begin
      ev_item.event_kind = (e_tag == pcd_pkg::TAG_IEND) ? pcd_pkg::EV_END
                                                        : pcd_pkg::EV_CHUNK;
      ev_item.chunk_tag  = e_tag;
      ev_item.stored_crc = crc_new;
    end
    ev_item.is_critical = !ev_bad
                          && (ev_item.chunk_tag[7:0] >= pcd_pkg::UPPER_FIRST)
                          && (ev_item.chunk_tag[7:0] <= pcd_pkg::UPPER_LAST);
    ev_item.image_width        = e_width;
    ev_item.image_height       = e_height;
    ev_item.bit_depth          = e_hdr[7:0];
    ev_item.color_type         = e_hdr[15:8];
    ev_item.compression_method = e_hdr[23:16];
    ev_item.filter_method      = e_hdr[31:24];
    ev_item.interlace_method   = e_hdr[39:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pcd_pkg::PH_SIG;
      idx_r    <= '0;
      len_r    <= '0;
      tag_r    <= '0;
      crc_r    <= '0;
      first_r  <= 1'b1;
      width_r  <= '0;
      height_r <= '0;
      hdr_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      tag_r    <= tag_nxt;
      crc_r    <= crc_nxt;
      first_r  <= first_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

endmodule

### rtl/png_chunk_deframer.sv
// Output: an event appears on out_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register is reloaded in the
// same cycle its item is taken, so a byte is accepted whenever the register
// is empty or being drained.
// Reset: synchronous, active low; parser returns to the signature phase and
// the output register is emptied.
// ----------------------------------------------------------------------------
// png_chunk_deframer
// Byte-serial PNG chunk deframer: checks the signature, walks the chunks and
// reports one event per finished chunk, bad signature or unknown tag, with IHDR fields captured.
// ----------------------------------------------------------------------------
module png_chunk_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcd_pkg::out_item_t  out_data
);

  logic               accept;
  logic               ev_valid;
  pcd_pkg::out_item_t ev_item;
  logic               out_valid_r;
  pcd_pkg::out_item_t out_item_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  pcd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .ev_valid (ev_valid),
    .ev_item  (ev_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && ev_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_valid) begin
      out_item_r <= ev_item;
    end
  end

  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_valid |=> out_valid_r)
    else $error("event lost between core and output register");

  a_bad_sig_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.event_kind == pcd_pkg::EV_BAD_SIG) |->
      (out_item_r.chunk_tag == 32'd0) && (out_item_r.stored_crc == 32'd0)
      && !out_item_r.is_critical)
    else $error("bad signature event carries chunk fields");

  a_unknown_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.event_kind == pcd_pkg::EV_UNKNOWN) |->
      (out_item_r.stored_crc == 32'd0))
    else $error("unknown tag event carries a crc");

  a_critical_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.is_critical |->
      (out_item_r.chunk_tag[7:0] >= pcd_pkg::UPPER_FIRST)
      && (out_item_r.chunk_tag[7:0] <= pcd_pkg::UPPER_LAST))
    else $error("critical flag without uppercase first tag byte");

endmodule

### test/tb_png_chunk_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_chunk_deframer
// Drives PNG byte streams into the chunk deframer with random gaps on both
// handshakes. A local parser model predicts each chunk event, and every event
// is checked field by field. Directed files come first, then random files.
// ----------------------------------------------------------------------------
module tb_png_chunk_deframer;

  typedef logic [7:0] byte_q_t[$];

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  pcd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pcd_pkg::out_item_t out_data;

  png_chunk_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb_png_chunk_deframer: FAIL");
    $finish;
  end

  localparam logic [7:0] PNG_MAGIC [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  string tag_names [21] = '{
    "IHDR", "PLTE", "IDAT", "IEND", "bKGD", "cHRM", "dSIG",
    "eXIf", "gAMA", "hIST", "iCCP", "iTXt", "pHYs", "sBIT",
    "sPLT", "sRGB", "sTER", "tEXt", "tIME", "tRNS", "zTXt"
  };
  localparam int IDX_IDAT = 2;
  localparam int IDX_IEND = 3;

  // parser model state
  pcd_pkg::phase_t phase = pcd_pkg::PH_SIG;
  logic [31:0] pos = '0;
  logic [31:0] len_acc = '0;
  logic [31:0] tag_acc = '0;
  logic [31:0] crc_acc = '0;
  logic        first_chunk = 1'b1;
  logic [31:0] hdr_width = '0;
  logic [31:0] hdr_height = '0;
  logic [39:0] hdr_bytes = '0;

  pcd_pkg::out_item_t pending_events[$];
  byte_q_t     no_body;
  bit          steady = 1'b0;
  int          errors = 0;
  int          events_checked = 0;
  int          bytes_parsed = 0;
  int          files_sent = 0;

  function automatic logic [31:0] tag_of(input string s);
    return {s[3], s[2], s[1], s[0]};
  endfunction

  function automatic bit tag_is_listed(input logic [31:0] t);
    bit hit;
    hit = 1'b0;
    foreach (tag_names[i]) begin
      if (tag_of(tag_names[i]) == t) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic queue_event(input logic [1:0] kind, input logic [31:0] t,
                             input logic [31:0] size, input logic [31:0] crc);
    pcd_pkg::out_item_t ev;
    ev.event_kind         = kind;
    ev.chunk_tag          = t;
    ev.chunk_size         = size;
    ev.is_critical        = (kind != pcd_pkg::EV_BAD_SIG)
                            && (t[7:0] >= "A") && (t[7:0] <= "Z");
    ev.stored_crc         = crc;
    ev.image_width        = hdr_width;
    ev.image_height       = hdr_height;
    ev.bit_depth          = hdr_bytes[7:0];
    ev.color_type         = hdr_bytes[15:8];
    ev.compression_method = hdr_bytes[23:16];
    ev.filter_method      = hdr_bytes[31:24];
    ev.interlace_method   = hdr_bytes[39:32];
    pending_events.push_back(ev);
  endtask

  task automatic deframe_byte(input pcd_pkg::in_item_t it);
    logic [7:0] b;
    logic [1:0] idx;
    b = it.data_byte;
    if (it.start_of_file) begin
      phase       = pcd_pkg::PH_SIG;
      pos         = '0;
      len_acc     = '0;
      tag_acc     = '0;
      crc_acc     = '0;
      first_chunk = 1'b1;
      hdr_width   = '0;
      hdr_height  = '0;
      hdr_bytes   = '0;
    end
    if (phase != pcd_pkg::PH_STOP) begin
      bytes_parsed++;
    end
    idx = pos[1:0];
    case (phase)
      pcd_pkg::PH_SIG: begin
        if (b != PNG_MAGIC[pos[2:0]]) begin
          phase = pcd_pkg::PH_STOP;
          queue_event(pcd_pkg::EV_BAD_SIG, '0, '0, '0);
        end else if (pos[2:0] == 3'd7) begin
          phase = pcd_pkg::PH_LEN;
          pos   = '0;
        end else begin
          pos = {29'd0, pos[2:0]} + 1;
        end
      end
      pcd_pkg::PH_LEN: begin
        if (idx == 2'd0) len_acc = '0;
        len_acc = {len_acc[23:0], b};
        if (idx == 2'd3) begin
          phase = pcd_pkg::PH_TAG;
          pos   = '0;
        end else begin
          pos = {30'd0, idx} + 1;
        end
      end
      pcd_pkg::PH_TAG: begin
        if (idx == 2'd0) tag_acc = '0;
        tag_acc[8*idx +: 8] = b;
        if (idx != 2'd3) begin
          pos = {30'd0, idx} + 1;
        end else begin
          pos = '0;
          if (!tag_is_listed(tag_acc)) begin
            phase = pcd_pkg::PH_STOP;
            queue_event(pcd_pkg::EV_UNKNOWN, tag_acc, len_acc, '0);
          end else begin
            phase = (len_acc == '0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
          end
        end
      end
      pcd_pkg::PH_DATA: begin
        if (first_chunk && tag_acc == tag_of("IHDR") && pos < 13) begin
          if (pos < 4) hdr_width[8*(3-pos) +: 8] = b;
          else if (pos < 8) hdr_height[8*(7-pos) +: 8] = b;
          else hdr_bytes[8*(pos-8) +: 8] = b;
        end
        pos = pos + 1;
        if (pos == len_acc) begin
          phase = pcd_pkg::PH_CRC;
          pos   = '0;
        end
      end
      pcd_pkg::PH_CRC: begin
        if (idx == 2'd0) crc_acc = '0;
        crc_acc[8*idx +: 8] = b;
        if (idx != 2'd3) begin
          pos = {30'd0, idx} + 1;
        end else begin
          pos         = '0;
          first_chunk = 1'b0;
          if (tag_acc == tag_of("IEND")) begin
            phase = pcd_pkg::PH_STOP;
            queue_event(pcd_pkg::EV_END, tag_acc, len_acc, crc_acc);
          end else begin
            phase = pcd_pkg::PH_LEN;
            queue_event(pcd_pkg::EV_CHUNK, tag_acc, len_acc, crc_acc);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic sof);
    pcd_pkg::in_item_t it;
    it = '{data_byte: b, start_of_file: sof};
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(it);
    @(negedge clk);
  endtask

  task automatic send_word_be(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) send_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_word_le(input logic [31:0] v);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_signature(input logic sof);
    files_sent++;
    for (int i = 0; i < 8; i++) send_byte(PNG_MAGIC[i], sof && i == 0);
  endtask

  // data bytes beyond the given body are random
  task automatic send_chunk(input logic [31:0] t, input int unsigned len,
                            input logic [31:0] crc, input byte_q_t body);
    send_word_be(len);
    send_word_le(t);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(i < body.size() ? body[i] : 8'($urandom_range(255)), 1'b0);
    end
    send_word_le(crc);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected item expected none actual %h", $time, out_data);
      end else begin
        pcd_pkg::out_item_t want;
        want = pending_events.pop_front();
        events_checked++;
        check_field("event_kind", want.event_kind, out_data.event_kind);
        check_field("chunk_tag", want.chunk_tag, out_data.chunk_tag);
        check_field("chunk_size", want.chunk_size, out_data.chunk_size);
        check_field("is_critical", want.is_critical, out_data.is_critical);
        check_field("stored_crc", want.stored_crc, out_data.stored_crc);
        check_field("image_width", want.image_width, out_data.image_width);
        check_field("image_height", want.image_height, out_data.image_height);
        check_field("bit_depth", want.bit_depth, out_data.bit_depth);
        check_field("color_type", want.color_type, out_data.color_type);
        check_field("compression_method", want.compression_method,
                    out_data.compression_method);
        check_field("filter_method", want.filter_method, out_data.filter_method);
        check_field("interlace_method", want.interlace_method,
                    out_data.interlace_method);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 36);
  end

  // no start flag after reset: parsed as a fresh file
  task automatic test_headerless_start();
    send_signature(1'b0);
    send_chunk(tag_of("IEND"), 0, 32'hAE42_6082, no_body);
    send_byte(8'h89, 1'b0);
  endtask

  task automatic test_signature_errors();
    send_byte(8'h00, 1'b1);
    send_byte(8'h89, 1'b1);
    send_byte(8'hFF, 1'b0);
    for (int i = 0; i < 7; i++) send_byte(PNG_MAGIC[i], i == 0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h50, 1'b0);
  endtask

  task automatic test_header_capture();
    byte_q_t body;
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
             8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_signature(1'b1);
    send_chunk(tag_of("IHDR"), 13, 32'hFFFF_FFFF, body);
    send_chunk(tag_of("IHDR"), 13, 32'h0000_0000, no_body);
    send_chunk(tag_of("tEXt"), 0, 32'h1234_5678, no_body);
    send_chunk(tag_of("IEND"), 0, 32'h8765_4321, no_body);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_header_sizes();
    send_signature(1'b1);
    send_chunk(tag_of("IHDR"), 5, $urandom(), no_body);
    send_chunk(tag_of("IEND"), 0, $urandom(), no_body);
    send_signature(1'b1);
    send_chunk(tag_of("IHDR"), 16, $urandom(), no_body);
    send_chunk(tag_of("IEND"), 0, $urandom(), no_body);
    send_signature(1'b1);
    send_chunk(tag_of("gAMA"), 4, $urandom(), no_body);
    send_chunk(tag_of("IHDR"), 13, $urandom(), no_body);
    send_chunk(tag_of("IEND"), 2, $urandom(), no_body);
  endtask

  task automatic test_unknown_tags();
    send_signature(1'b1);
    send_word_be(32'hFFFF_FFFF);
    send_word_le(tag_of("ABCD"));
    send_byte(8'h12, 1'b0);
    send_signature(1'b1);
    send_chunk(tag_of("pHYs"), 1, $urandom(), no_body);
    send_word_be(32'h0000_0000);
    send_word_le(tag_of("Zzzz"));
    send_signature(1'b1);
    send_word_be(32'h8000_0001);
    send_word_le(tag_of("@xyz"));
    send_signature(1'b1);
    send_word_be(32'h0000_0005);
    send_word_le(tag_of("[xyz"));
  endtask

  task automatic test_restart_midchunk();
    send_signature(1'b1);
    send_word_be(32'd13);
    send_word_le(tag_of("IHDR"));
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_signature(1'b1);
    send_chunk(tag_of("IEND"), 0, $urandom(), no_body);
  endtask

  task automatic random_file();
    int unsigned mode;
    int unsigned k;
    int unsigned n;
    mode = $urandom_range(99);
    if (mode < 10) begin
      files_sent++;
      k = $urandom_range(7);
      for (int unsigned i = 0; i <= k; i++) begin
        send_byte(i == k ? PNG_MAGIC[i] ^ 8'($urandom_range(255, 1)) : PNG_MAGIC[i],
                  i == 0);
      end
    end else if (mode < 14) begin
      n = $urandom_range(6, 1);
      for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == 0);
    end else begin
      send_signature(1'b1);
      if ($urandom_range(99) < 75) begin
        send_chunk(tag_of("IHDR"), ($urandom_range(99) < 80) ? 13 : $urandom_range(20),
                   $urandom(), no_body);
      end
      repeat ($urandom_range(4)) begin
        k = $urandom_range(20);
        if (k == IDX_IEND) k = IDX_IDAT;
        send_chunk(tag_of(tag_names[k]),
                   ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(48, 13),
                   $urandom(), no_body);
      end
      mode = $urandom_range(99);
      if (mode < 75) begin
        send_chunk(tag_of("IEND"), ($urandom_range(99) < 80) ? 0 : $urandom_range(4, 1),
                   $urandom(), no_body);
      end else if (mode < 85) begin
        send_word_be($urandom());
        send_word_le($urandom());
      end else if (mode < 95) begin
        repeat ($urandom_range(11, 1)) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        send_word_be($urandom() | 32'h8000_0000);
        send_word_le(tag_of("IDAT"));
        repeat ($urandom_range(8)) send_byte(8'($urandom_range(255)), 1'b0);
      end
    end
    n = ($urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_random_files();
    int base;
    int file_no;
    base    = bytes_parsed;
    file_no = 0;
    while (bytes_parsed - base < 950) begin
      steady = (file_no >= 6 && file_no < 11);
      if (file_no % 7 == 4) wait_drained();
      random_file();
      file_no++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_headerless_start();
    test_signature_errors();
    test_header_capture();
    test_header_sizes();
    test_unknown_tags();
    test_restart_midchunk();
    test_random_files();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("files started: %0d, bytes parsed: %0d, chunk events checked: %0d",
             files_sent, bytes_parsed, events_checked);
    $display("covered bad signatures, unknown tags, IHDR capture, restarts, stalls");
    if (errors == 0) begin
      $display("tb_png_chunk_deframer: PASS");
    end else begin
      $display("tb_png_chunk_deframer: FAIL");
    end
    $finish;
  end

endmodule
